// ===== rtl/core/lcg_pkg.sv =====
// Shared types and constants for the Legendre coefficient generator.
package lcg_pkg;

    localparam int ORDER_W        = 5;   // order, power and scale shift
    localparam int NUM_W          = 64;  // row entry width
    localparam int NUMER_W        = 63;  // emitted numerator width
    localparam int NORM_W         = 6;   // 2n+1
    localparam int COEF_W         = 7;   // recurrence multipliers 4i-2, 4i-4
    localparam int PROD_W         = NUM_W + COEF_W + 1;
    localparam int DIV_DIGIT_BITS = 4;   // quotient bits per divider cycle
    localparam int DIV_STEPS      = NUM_W / DIV_DIGIT_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int IN_TDATA_W     = 8;
    localparam int OUT_TDATA_W    = 80;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_READ,
        ST_MUL,
        ST_SUB,
        ST_START,
        ST_DIV,
        ST_WRITE,
        ST_ERD,
        ST_LOAD,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/core/legendre_coefficient_generator.sv =====
// Top level: sequencer and datapath of the Legendre recurrence over two row stores.
// Flow: the rows are seeded first, then each coefficient update runs read, multiply,
// subtract, iterative divide and write back, (n+1)(n+2)/2 - 3 updates for order n >= 2;
// each emitted coefficient is then read, loaded and held until it is taken.
// One order in flight at a time; an out-of-range order gives one result.
// Synchronous active-low reset returns to idle; row stores are rebuilt on every in-range order.
module legendre_coefficient_generator #(
    parameter int MAX_ORDER = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [4:0] order, [7:5] zero
    input  logic [lcg_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [4:0] power, [67:5] numerator, [72:68] scale_shift, [78:73] norm_denominator,
    // [79] zero
    output logic [lcg_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // [0] out_of_range
    output logic [0:0]                         o_m_axis_tuser,
    output logic                               o_m_axis_tlast
);

    localparam int ROW_LEN = MAX_ORDER + 1;
    localparam int AW      = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;

    lcg_pkg::t_state r_state, n_state;

    logic [lcg_pkg::ORDER_W-1:0]  r_n, n_n;
    logic [lcg_pkg::ORDER_W-1:0]  r_i, n_i;
    logic [lcg_pkg::ORDER_W-1:0]  r_j, n_j;
    logic                         r_sel, n_sel;     // 0: bank A holds the older row
    logic                         r_mask_up, n_mask_up;
    logic                         r_mask_dn, n_mask_dn;
    logic                         r_neg, n_neg;
    logic                         r_final, n_final;
    logic                         r_out_valid, n_out_valid;

    logic signed [lcg_pkg::NUM_W-1:0] r_pa, n_pa;
    logic signed [lcg_pkg::NUM_W-1:0] r_pb, n_pb;
    logic signed [lcg_pkg::NUM_W-1:0] r_diff, n_diff;

    logic [lcg_pkg::ORDER_W-1:0]  r_out_power, n_out_power;
    logic [lcg_pkg::NUMER_W-1:0]  r_out_num, n_out_num;
    logic [lcg_pkg::ORDER_W-1:0]  r_out_shift, n_out_shift;
    logic [lcg_pkg::NORM_W-1:0]   r_out_norm, n_out_norm;
    logic                         r_out_oor, n_out_oor;
    logic                         r_out_last, n_out_last;

    logic [lcg_pkg::ORDER_W-1:0]  w_order;
    logic [lcg_pkg::ORDER_W-1:0]  w_jm1;
    logic [lcg_pkg::ORDER_W-1:0]  w_new_idx;
    logic [lcg_pkg::COEF_W-1:0]   w_a;
    logic [lcg_pkg::COEF_W-1:0]   w_b;
    logic signed [lcg_pkg::NUM_W-1:0]  w_up;
    logic signed [lcg_pkg::NUM_W-1:0]  w_dn;
    logic signed [lcg_pkg::PROD_W-1:0] w_prod_a;
    logic signed [lcg_pkg::PROD_W-1:0] w_prod_b;
    logic [lcg_pkg::NUM_W-1:0]    w_old_data;
    logic [lcg_pkg::NUM_W-1:0]    w_new_data;
    logic [lcg_pkg::NUM_W-1:0]    w_res_data;
    logic [lcg_pkg::NUM_W-1:0]    w_quot;
    logic [lcg_pkg::NUM_W-1:0]    w_wr_data;
    logic                         w_div_start;
    logic                         w_div_done;
    logic [lcg_pkg::NUM_W-1:0]    w_dividend;

    logic                         w_clr;
    logic                         w_wr;
    logic                         w_a_we, w_b_we;
    logic [AW-1:0]                w_a_raddr, w_b_raddr;
    logic [lcg_pkg::NUM_W-1:0]    w_a_wdata, w_b_wdata;
    logic [lcg_pkg::NUM_W-1:0]    w_a_rdata, w_b_rdata;

    assign w_order   = i_s_axis_tdata[lcg_pkg::ORDER_W-1:0];
    assign w_jm1     = r_j - lcg_pkg::ORDER_W'(1);
    assign w_new_idx = (r_state == lcg_pkg::ST_READ) ? w_jm1 : r_j;

    // a = 2(2i-1), b = 4(i-1)
    assign w_a = {r_i, 2'b00} - lcg_pkg::COEF_W'(2);
    assign w_b = {r_i, 2'b00} - lcg_pkg::COEF_W'(4);

    // Bank roles swap after each finished row instead of copying.
    assign w_a_raddr  = r_sel ? w_new_idx[AW-1:0] : r_j[AW-1:0];
    assign w_b_raddr  = r_sel ? r_j[AW-1:0] : w_new_idx[AW-1:0];
    assign w_old_data = r_sel ? w_b_rdata : w_a_rdata;
    assign w_new_data = r_sel ? w_a_rdata : w_b_rdata;
    assign w_res_data = (r_n == '0) ? w_old_data : w_new_data;

    assign w_up     = r_mask_up ? '0 : $signed(w_new_data);
    assign w_dn     = r_mask_dn ? '0 : $signed(w_old_data);
    assign w_prod_a = w_up * $signed({1'b0, w_a});
    assign w_prod_b = w_dn * $signed({1'b0, w_b});

    assign w_div_start = (r_state == lcg_pkg::ST_START);
    assign w_dividend  = r_diff[lcg_pkg::NUM_W-1] ? lcg_pkg::NUM_W'(-r_diff)
                                                  : lcg_pkg::NUM_W'(r_diff);
    assign w_wr_data   = r_neg ? (~w_quot + lcg_pkg::NUM_W'(1)) : w_quot;

    // Seeding writes N_0 into the older bank and N_1 into the newer one; a result
    // overwrites the older row in place, since that entry is already consumed.
    assign w_clr     = (r_state == lcg_pkg::ST_CLEAR);
    assign w_wr      = (r_state == lcg_pkg::ST_WRITE);
    assign w_a_we    = w_clr || (w_wr && !r_sel);
    assign w_b_we    = w_clr || (w_wr && r_sel);
    assign w_a_wdata = w_clr ? lcg_pkg::NUM_W'(r_j == lcg_pkg::ORDER_W'(0)) : w_wr_data;
    assign w_b_wdata = w_clr ? lcg_pkg::NUM_W'(r_j == lcg_pkg::ORDER_W'(1)) : w_wr_data;

    lcg_row_mem #(
        .DEPTH (ROW_LEN),
        .AW    (AW)
    ) u_bank_a (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (r_j[AW-1:0]),
        .i_wdata (w_a_wdata),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rdata)
    );

    lcg_row_mem #(
        .DEPTH (ROW_LEN),
        .AW    (AW)
    ) u_bank_b (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (r_j[AW-1:0]),
        .i_wdata (w_b_wdata),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    lcg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_i),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_i         = r_i;
        n_j         = r_j;
        n_sel       = r_sel;
        n_mask_up   = r_mask_up;
        n_mask_dn   = r_mask_dn;
        n_neg       = r_neg;
        n_final     = r_final;
        n_out_valid = r_out_valid;
        n_pa        = r_pa;
        n_pb        = r_pb;
        n_diff      = r_diff;
        n_out_power = r_out_power;
        n_out_num   = r_out_num;
        n_out_shift = r_out_shift;
        n_out_norm  = r_out_norm;
        n_out_oor   = r_out_oor;
        n_out_last  = r_out_last;

        unique case (r_state)
            lcg_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_n = w_order;
                    if (w_order > lcg_pkg::ORDER_W'(MAX_ORDER)) begin
                        n_out_power = '0;
                        n_out_num   = '0;
                        n_out_shift = '0;
                        n_out_norm  = '0;
                        n_out_oor   = 1'b1;
                        n_out_last  = 1'b0;
                        n_final     = 1'b1;
                        n_out_valid = 1'b1;
                        n_state     = lcg_pkg::ST_OUT;
                    end else begin
                        n_j     = '0;
                        n_sel   = 1'b0;
                        n_state = lcg_pkg::ST_CLEAR;
                    end
                end
            end
            lcg_pkg::ST_CLEAR: begin
                if (r_j == lcg_pkg::ORDER_W'(MAX_ORDER)) begin
                    n_j = '0;
                    if (r_n < lcg_pkg::ORDER_W'(2)) begin
                        n_state = lcg_pkg::ST_ERD;
                    end else begin
                        n_i     = lcg_pkg::ORDER_W'(2);
                        n_state = lcg_pkg::ST_READ;
                    end
                end else begin
                    n_j = r_j + lcg_pkg::ORDER_W'(1);
                end
            end
            lcg_pkg::ST_READ: begin
                n_mask_up = (r_j == '0);
                n_mask_dn = ((r_j + lcg_pkg::ORDER_W'(2)) > r_i);
                n_state   = lcg_pkg::ST_MUL;
            end
            lcg_pkg::ST_MUL: begin
                n_pa    = w_prod_a[lcg_pkg::NUM_W-1:0];
                n_pb    = w_prod_b[lcg_pkg::NUM_W-1:0];
                n_state = lcg_pkg::ST_SUB;
            end
            lcg_pkg::ST_SUB: begin
                n_diff  = r_pa - r_pb;
                n_state = lcg_pkg::ST_START;
            end
            lcg_pkg::ST_START: begin
                n_neg   = r_diff[lcg_pkg::NUM_W-1];
                n_state = lcg_pkg::ST_DIV;
            end
            lcg_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = lcg_pkg::ST_WRITE;
                end
            end
            lcg_pkg::ST_WRITE: begin
                if (r_j == r_i) begin
                    n_j   = '0;
                    n_sel = ~r_sel;
                    if (r_i == r_n) begin
                        n_state = lcg_pkg::ST_ERD;
                    end else begin
                        n_i     = r_i + lcg_pkg::ORDER_W'(1);
                        n_state = lcg_pkg::ST_READ;
                    end
                end else begin
                    n_j     = r_j + lcg_pkg::ORDER_W'(1);
                    n_state = lcg_pkg::ST_READ;
                end
            end
            lcg_pkg::ST_ERD: begin
                n_state = lcg_pkg::ST_LOAD;
            end
            lcg_pkg::ST_LOAD: begin
                n_out_power = r_j;
                n_out_num   = w_res_data[lcg_pkg::NUMER_W-1:0];
                n_out_shift = r_n;
                n_out_norm  = {r_n, 1'b1};
                n_out_oor   = 1'b0;
                n_out_last  = (r_j == r_n);
                n_final     = (r_j == r_n);
                n_out_valid = 1'b1;
                n_state     = lcg_pkg::ST_OUT;
            end
            lcg_pkg::ST_OUT: begin
                if (i_m_axis_tready) begin
                    n_out_valid = 1'b0;
                    if (r_final) begin
                        n_state = lcg_pkg::ST_IDLE;
                    end else begin
                        n_j     = r_j + lcg_pkg::ORDER_W'(1);
                        n_state = lcg_pkg::ST_ERD;
                    end
                end
            end
            default: begin
                n_state = lcg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcg_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_i         <= n_i;
        r_j         <= n_j;
        r_sel       <= n_sel;
        r_mask_up   <= n_mask_up;
        r_mask_dn   <= n_mask_dn;
        r_neg       <= n_neg;
        r_final     <= n_final;
        r_pa        <= n_pa;
        r_pb        <= n_pb;
        r_diff      <= n_diff;
        r_out_power <= n_out_power;
        r_out_num   <= n_out_num;
        r_out_shift <= n_out_shift;
        r_out_norm  <= n_out_norm;
        r_out_oor   <= n_out_oor;
        r_out_last  <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == lcg_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_norm, r_out_shift, r_out_num, r_out_power};
    assign o_m_axis_tuser  = r_out_oor;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== rtl/core/lcg_row_mem.sv =====
// One row store: single write port, single registered read port.
module lcg_row_mem #(
    parameter int DEPTH = 17,
    parameter int AW    = 5
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lcg_pkg::NUM_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [lcg_pkg::NUM_W-1:0] o_rdata
);

    logic [lcg_pkg::NUM_W-1:0] r_mem [DEPTH];
    logic [lcg_pkg::NUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/lcg_div.sv =====
// Iterative unsigned divider by a small divisor, four quotient bits per cycle.
module lcg_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lcg_pkg::NUM_W-1:0]   i_dividend,
    input  logic [lcg_pkg::ORDER_W-1:0] i_divisor,
    output logic                        o_done,
    output logic [lcg_pkg::NUM_W-1:0]   o_quot
);

    logic                            r_busy;
    logic                            r_done;
    logic [lcg_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [lcg_pkg::NUM_W-1:0]       r_quo;
    logic [lcg_pkg::ORDER_W-1:0]     r_rem;
    logic [lcg_pkg::ORDER_W-1:0]     r_dvs;
    logic [lcg_pkg::NUM_W-1:0]       n_quo;
    logic [lcg_pkg::ORDER_W-1:0]     n_rem;

    // Remainder stays below the divisor, so it fits the order width.
    always_comb begin
        logic [lcg_pkg::ORDER_W:0]   t_w;
        logic [lcg_pkg::NUM_W-1:0]   t_q;
        logic [lcg_pkg::ORDER_W-1:0] t_r;
        t_q = r_quo;
        t_r = r_rem;
        for (int s = 0; s < lcg_pkg::DIV_DIGIT_BITS; s++) begin
            t_w = {t_r, t_q[lcg_pkg::NUM_W-1]};
            t_q = {t_q[lcg_pkg::NUM_W-2:0], 1'b0};
            if (t_w >= {1'b0, r_dvs}) begin
                t_w    = t_w - {1'b0, r_dvs};
                t_q[0] = 1'b1;
            end
            t_r = t_w[lcg_pkg::ORDER_W-1:0];
        end
        n_quo = t_q;
        n_rem = t_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == lcg_pkg::DIV_CNT_W'(lcg_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== tb/tb_legendre_coefficient_generator.sv =====
// Self-checking bench for the Legendre coefficient generator: random orders, stalls, scoreboard.
module tb_legendre_coefficient_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ORDER   = 16;
    localparam int ROW_LEN     = MAX_ORDER + 1;
    localparam int RAND_ORDERS = 125;
    localparam int CYCLE_LIMIT = 2_500_000;

    typedef struct {
        logic [lcg_pkg::ORDER_W-1:0] power;
        logic [lcg_pkg::NUMER_W-1:0] numerator;
        logic [lcg_pkg::ORDER_W-1:0] scale_shift;
        logic [lcg_pkg::NORM_W-1:0]  norm_denominator;
        logic                        out_of_range;
        logic                        last;
    } t_coef;

    class coef_scoreboard;
        longint older_row[ROW_LEN];
        longint newer_row[ROW_LEN];
        t_coef  pending_coefs[$];
        int     failures;

        function new();
            foreach (older_row[j]) begin
                older_row[j] = 0;
                newer_row[j] = 0;
            end
            failures = 0;
        endfunction

        // Runs the integer recurrence N_i = (2(2i-1) x N_{i-1} - 4(i-1) N_{i-2}) / i and queues
        // the coefficients of N_n, lowest power first, or one out-of-range entry above MAX_ORDER.
        function void note_order(logic [lcg_pkg::ORDER_W-1:0] ord);
            longint nxt[ROW_LEN];
            longint mul_up, mul_down, up, down;
            t_coef  c;
            int     n;
            n = ord;
            if (n > MAX_ORDER) begin
                c = '{default: '0};
                c.out_of_range = 1'b1;
                pending_coefs.push_back(c);
                return;
            end
            foreach (older_row[j]) begin
                older_row[j] = 0;
                newer_row[j] = 0;
            end
            older_row[0] = 1;
            newer_row[1] = 1;
            for (int i = 2; i <= n; i++) begin
                mul_up   = 2 * (2 * i - 1);
                mul_down = 4 * (i - 1);
                for (int j = 0; j < ROW_LEN; j++) begin
                    if (j <= i) begin
                        up     = (j >= 1) ? newer_row[j-1] : 0;
                        down   = (j <= i - 2) ? older_row[j] : 0;
                        nxt[j] = (mul_up * up - mul_down * down) / longint'(i);
                    end else begin
                        nxt[j] = 0;
                    end
                end
                older_row = newer_row;
                newer_row = nxt;
            end
            for (int k = 0; k <= n; k++) begin
                c.power            = k[lcg_pkg::ORDER_W-1:0];
                c.numerator        = (n == 0) ? older_row[k][lcg_pkg::NUMER_W-1:0]
                                              : newer_row[k][lcg_pkg::NUMER_W-1:0];
                c.scale_shift      = ord;
                c.norm_denominator = lcg_pkg::NORM_W'(2 * n + 1);
                c.out_of_range     = 1'b0;
                c.last             = (k == n);
                pending_coefs.push_back(c);
            end
        endfunction

        function void cmp_field(string name, logic [lcg_pkg::NUMER_W-1:0] exp_v,
                                logic [lcg_pkg::NUMER_W-1:0] act_v);
            if (exp_v !== act_v) begin
                failures++;
                $display("%0t ns: %s expected %0h actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [lcg_pkg::OUT_TDATA_W-1:0] data, logic oor,
                                   logic lst);
            t_coef c;
            if (pending_coefs.size() == 0) begin
                failures++;
                $display("%0t ns: unexpected transaction, expected none actual data %0h",
                         $time, data);
                return;
            end
            c = pending_coefs.pop_front();
            cmp_field("power", c.power, data[4:0]);
            cmp_field("numerator", c.numerator, data[67:5]);
            cmp_field("scale_shift", c.scale_shift, data[72:68]);
            cmp_field("norm_denominator", c.norm_denominator, data[78:73]);
            cmp_field("out_of_range", c.out_of_range, oor);
            cmp_field("last", c.last, lst);
        endfunction

        function int outstanding();
            return pending_coefs.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_axis_tvalid;
    logic                            o_s_axis_tready;
    logic [lcg_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;   // [4:0] order, [7:5] zero
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready;
    // [4:0] power, [67:5] numerator, [72:68] scale_shift, [78:73] norm_denominator, [79] zero
    logic [lcg_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic [0:0]                      o_m_axis_tuser;   // [0] out_of_range
    logic                            o_m_axis_tlast;

    coef_scoreboard sb = new();
    bit             steady;   // suppresses idling on both sides
    int unsigned    cycles;

    legendre_coefficient_generator #(.MAX_ORDER(MAX_ORDER)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        steady          = 1'b0;
        cycles          = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: sample the handshake as seen at the edge, then reroll ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata, o_m_axis_tuser[0], o_m_axis_tlast);
        if (!i_rst_n)
            i_m_axis_tready <= 1'b0;
        else
            i_m_axis_tready <= steady || ($urandom_range(99) >= 24);
    end

    // called at a rising edge; returns at the edge where the order was taken
    task automatic send_order(input logic [lcg_pkg::ORDER_W-1:0] ord);
        if (!steady && $urandom_range(99) < 24) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 24);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(lcg_pkg::IN_TDATA_W-lcg_pkg::ORDER_W){1'b0}}, ord};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_order(ord);
    endtask

    function automatic logic [lcg_pkg::ORDER_W-1:0] pick_order();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return lcg_pkg::ORDER_W'($urandom_range(8));
        else if (roll < 85)
            return lcg_pkg::ORDER_W'($urandom_range(MAX_ORDER, 9));
        else
            return lcg_pkg::ORDER_W'($urandom_range(31, MAX_ORDER + 1));
    endfunction

    initial begin
        logic [lcg_pkg::ORDER_W-1:0] directed[] = '{0, 1, 2, 3, 4, 5, 16, 17, 31, 24, 18,
                                                    10, 15, 0, 16, 7, 9, 11, 12, 13, 14,
                                                    6, 8, 19, 25};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[d])
            send_order(directed[d]);

        for (int r = 0; r < RAND_ORDERS; r++) begin
            steady = (r >= 40 && r < 80);
            send_order(pick_order());
        end
        steady = 1'b0;
        i_s_axis_tvalid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        // catch stray transactions after the last expected coefficient
        repeat (200) @(posedge i_clk);
        if (sb.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== legendre_coefficient_generator.f =====
rtl/core/lcg_pkg.sv
rtl/core/lcg_row_mem.sv
rtl/core/lcg_div.sv
rtl/core/legendre_coefficient_generator.sv
tb/tb_legendre_coefficient_generator.sv
